// File: rtl/mtwm_pkg.sv
// ----------------------------------------------------------------------------
// mtwm_pkg
// Shared constants, widths and helpers for the media-type wildcard matcher.
// ----------------------------------------------------------------------------
package mtwm_pkg;

   // Pattern store depth and derived widths
   localparam int PATTERN_DEPTH = 64;
   localparam int ADDR_W        = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [7:0]        byte_type;

   // Transaction function codes
   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_APPEND  = 2'd1,
      FUNC_SUBJECT = 2'd2,
      FUNC_END     = 2'd3
   } func_type;

   // Special characters
   localparam byte_type STAR_CHAR  = 8'h2A;
   localparam byte_type SEMI_CHAR  = 8'h3B;
   localparam byte_type SPACE_CHAR = 8'h20;
   localparam byte_type UPPER_A    = 8'h41;
   localparam byte_type UPPER_Z    = 8'h5A;
   localparam byte_type CASE_DELTA = 8'h20;

   // ASCII upper case to lower case, other bytes unchanged
   function automatic byte_type fold_case(input byte_type c);
      byte_type r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// File: rtl/media_type_wildcard_match_unit.sv
// ----------------------------------------------------------------------------
// media_type_wildcard_match_unit
// Streams a subject byte by byte against a stored media-type pattern held in
// a synchronous single-port-write / one-read memory.
// ----------------------------------------------------------------------------
// Sequencing: clear and append complete in idle on acceptance; a subject
//   byte is compared in S_CMP, one more memory read per skipped pattern
//   space or star exit, or is ignored in idle (after a mismatch, empty
//   pattern, pattern used up); end of subject passes through S_END, whose
//   result is registered; it waits in S_END while the previous result stalls.
// Throughput: one transaction at a time; requests stall outside S_IDLE.
// Reset: synchronous, clears length, position and flags; the pattern memory
//   is not cleared and only entries below the length are ever compared.
module media_type_wildcard_match_unit (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  mtwm_pkg::byte_type req_data_byte,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_match,
   output logic              rsp_pattern_overflowed
);
   import mtwm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_END  = 2'd2;

   // control state
   logic [1:0] state_ff, state_in;
   len_type    len_ff, len_in;
   len_type    pos_ff, pos_in;
   logic       mismatch_ff, mismatch_in;
   logic       overflow_ff, overflow_in;
   logic       rsp_valid_ff, rsp_valid_in;
   // payload
   byte_type   subj_ff, subj_in;
   logic       rsp_match_ff, rsp_match_in;
   logic       rsp_ovf_ff, rsp_ovf_in;

   // pattern memory
   byte_type   pattern_mem [PATTERN_DEPTH];
   byte_type   rd_data_ff;
   addr_type   rd_addr;
   logic       wr_en;
   addr_type   wr_addr;

   logic       accept;
   logic       slot_free;
   len_type    pos_p1;
   byte_type   p;
   func_type   func;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign func      = func_type'(req_func);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pos_p1    = pos_ff + len_type'(1);
   assign p         = rd_data_ff;

   // read address: next entry while walking, else current position
   assign rd_addr = (state_ff == S_CMP) ? pos_p1[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];
   assign wr_addr = len_ff[ADDR_W-1:0];

   // pattern memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= req_data_byte;
      end
      rd_data_ff <= pattern_mem[rd_addr];
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      mismatch_in  = mismatch_ff;
      overflow_in  = overflow_ff;
      subj_in      = subj_ff;
      rsp_match_in = rsp_match_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               subj_in = req_data_byte;
               case (func)
                  FUNC_CLEAR: begin
                     len_in      = '0;
                     pos_in      = '0;
                     mismatch_in = 1'b0;
                     overflow_in = 1'b0;
                  end
                  FUNC_APPEND: begin
                     if (len_ff < len_type'(PATTERN_DEPTH)) begin
                        wr_en  = 1'b1;
                        len_in = len_ff + len_type'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  FUNC_SUBJECT: begin
                     if (!mismatch_ff && len_ff != '0) begin
                        if (pos_ff >= len_ff) begin
                           mismatch_in = 1'b1;
                        end else begin
                           state_in = S_CMP;
                        end
                     end
                  end
                  default: begin
                     state_in = S_END;
                  end
               endcase
            end
         end

         // compare one pattern entry against the latched subject byte
         S_CMP: begin
            if (p == SPACE_CHAR || (p == STAR_CHAR && subj_ff == SEMI_CHAR)) begin
               pos_in = pos_p1;
               if (pos_p1 >= len_ff) begin
                  mismatch_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (subj_ff == SPACE_CHAR || p == STAR_CHAR) begin
               state_in = S_IDLE;
            end else if (fold_case(p) != fold_case(subj_ff)) begin
               mismatch_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               pos_in   = pos_p1;
               state_in = S_IDLE;
            end
         end

         // verdict at end of subject, once the output register is free
         S_END: begin
            if (slot_free) begin
               if (len_ff == '0) begin
                  rsp_match_in = 1'b1;
               end else if (mismatch_ff) begin
                  rsp_match_in = 1'b0;
               end else if (pos_ff < len_ff && p == STAR_CHAR) begin
                  rsp_match_in = (pos_p1 >= len_ff);
               end else begin
                  rsp_match_in = (pos_ff >= len_ff);
               end
               rsp_ovf_in   = overflow_ff;
               rsp_valid_in = 1'b1;
               pos_in       = '0;
               mismatch_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pos_ff       <= '0;
         mismatch_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         mismatch_ff  <= mismatch_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      subj_ff      <= subj_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_match              = rsp_match_ff;
   assign rsp_pattern_overflowed = rsp_ovf_ff;

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= len_type'(PATTERN_DEPTH))
      else $error("pattern length beyond store depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("pattern position beyond pattern length");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_END))
      else $error("response raised outside end-of-subject handling");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (pos_ff < len_ff))
      else $error("pattern read beyond written entries");

endmodule
